FILE: design/assert_macros.svh
// Assertion macros shared by the priority queue RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising edge, skipped while reset is high.
`define MLPQ_ASSERT(label, ck, rs, prop, msg) \
  label: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);
// Check a property on every rising edge, reset included.
`define MLPQ_ASSERT_ALWAYS(label, ck, prop, msg) \
  label: assert property (@(posedge ck) prop) else $error(msg);
`else
`define MLPQ_ASSERT(label, ck, rs, prop, msg)
`define MLPQ_ASSERT_ALWAYS(label, ck, prop, msg)
`endif

`endif

FILE: design/mlpq_pkg.sv
// Package for the multilevel priority queue: payload types, codes and defaults.
`default_nettype none

package mlpq_pkg;

  // Default sizing of the bank.
  localparam int NUM_LEVELS_DEF  = 8;
  localparam int LEVEL_DEPTH_DEF = 16;
  localparam int TASK_BITS_DEF   = 16;

  // Fixed field widths of the payloads.
  localparam int KIND_W   = 2;
  localparam int TASK_W   = 16;
  localparam int PRIO_W   = 4;
  localparam int TOTAL_W  = 8;
  localparam int LCOUNT_W = 5;
  localparam int STATUS_W = 2;

  // Operation codes; the unused code acts as a query.
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADD    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_DROP  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TASK_W-1:0] task_id;
    logic [PRIO_W-1:0] priority_req;
  } mlpq_req_t;

  typedef struct packed {
    logic                front_valid;
    logic [TASK_W-1:0]   front_task;
    logic [PRIO_W-1:0]   front_priority;
    logic [TOTAL_W-1:0]  total_count;
    logic [LCOUNT_W-1:0] level_count;
    logic [STATUS_W-1:0] status;
  } mlpq_rsp_t;

  // Update command to the level bookkeeping.
  typedef struct packed {
    logic add;
    logic remove;
  } lvl_cmd_t;

  // Flags back from the level bookkeeping.
  typedef struct packed {
    logic any;
    logic sel_full;
  } lvl_stat_t;

endpackage

`default_nettype wire

FILE: design/mlpq_store.sv
// Task store: one write port, one read port with registered read data.
`default_nettype none

module mlpq_store import mlpq_pkg::*; #(
  parameter int NUM_LEVELS  = NUM_LEVELS_DEF,
  parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF,
  parameter int TASK_BITS   = TASK_BITS_DEF,
  localparam int Entries    = NUM_LEVELS * LEVEL_DEPTH,
  localparam int AW         = $clog2(Entries)
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [AW-1:0]        wr_addr,
  input  wire logic [TASK_BITS-1:0] wr_data,
  input  wire logic                 rd_en,
  input  wire logic [AW-1:0]        rd_addr,
  output logic      [TASK_BITS-1:0] rd_data
);

  logic [TASK_BITS-1:0] mem [Entries];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: design/mlpq_levels.sv
// Per-level ring pointers, fill counts, total count and front-level encoder.
`default_nettype none

`include "assert_macros.svh"

module mlpq_levels import mlpq_pkg::*; #(
  parameter int NUM_LEVELS  = NUM_LEVELS_DEF,
  parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF,
  localparam int LW         = $clog2(NUM_LEVELS),
  localparam int PW         = $clog2(LEVEL_DEPTH),
  localparam int FW         = $clog2(LEVEL_DEPTH + 1),
  localparam int TW         = $clog2(NUM_LEVELS * LEVEL_DEPTH + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire lvl_cmd_t      cmd,
  input  wire logic [LW-1:0] sel_lvl,
  output lvl_stat_t          stat,
  output logic      [LW-1:0] top_lvl,
  output logic      [PW-1:0] top_slot,
  output logic      [PW-1:0] sel_slot,
  output logic      [FW-1:0] sel_fill,
  output logic      [TW-1:0] total
);

  logic [PW-1:0] head [NUM_LEVELS];
  logic [PW-1:0] tail [NUM_LEVELS];
  logic [FW-1:0] fill [NUM_LEVELS];

  function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
    return (p == PW'(LEVEL_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Highest non-empty level wins.
  always_comb begin
    stat.any      = 1'b0;
    stat.sel_full = (fill[sel_lvl] == FW'(LEVEL_DEPTH));
    top_lvl       = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (fill[i] != '0) begin
        stat.any = 1'b1;
        top_lvl  = LW'(i);
      end
    end
  end

  assign sel_fill      = fill[sel_lvl];
  assign sel_slot      = tail[sel_lvl];
  assign top_slot      = head[top_lvl];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head[i] <= '0;
        tail[i] <= '0;
        fill[i] <= '0;
      end
      total <= '0;
    end else begin
      if (cmd.add) begin
        tail[sel_lvl] <= ring_next(tail[sel_lvl]);
        fill[sel_lvl] <= fill[sel_lvl] + 1'b1;
        total         <= total + 1'b1;
      end else if (cmd.remove) begin
        head[top_lvl] <= ring_next(head[top_lvl]);
        fill[top_lvl] <= fill[top_lvl] - 1'b1;
        total         <= total - 1'b1;
      end
    end
  end

  `MLPQ_ASSERT(a_remove_nonempty, clk, rst, cmd.remove |-> stat.any, "remove on empty bank")
  `MLPQ_ASSERT(a_add_room, clk, rst, cmd.add |-> !stat.sel_full, "add into full level")
  `MLPQ_ASSERT(a_total_any, clk, rst, (total == '0) |-> !stat.any, "total disagrees with fills")

endmodule

`default_nettype wire

FILE: design/multilevel_priority_queue.sv
// Top level of the multilevel strict-priority task queue.
// Sequence: an accepted item updates the bank, then the store reads the new
//   front task and the result is loaded into the output register to wait there
//   until taken. A new item is accepted only in idle, after the last result
//   has been loaded.
// Reset: synchronous; empties every level at once, no clearing pass; store
//   contents stay undefined until written.
`default_nettype none

`include "assert_macros.svh"

module multilevel_priority_queue import mlpq_pkg::*; #(
  parameter int NUM_LEVELS  = NUM_LEVELS_DEF,
  parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF,
  parameter int TASK_BITS   = TASK_BITS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  output logic           req_ready,
  input  wire mlpq_req_t req,
  output logic           rsp_valid,
  input  wire logic      rsp_ready,
  output mlpq_rsp_t      rsp
);

  localparam int LW = $clog2(NUM_LEVELS);
  localparam int PW = $clog2(LEVEL_DEPTH);
  localparam int FW = $clog2(LEVEL_DEPTH + 1);
  localparam int TW = $clog2(NUM_LEVELS * LEVEL_DEPTH + 1);
  localparam int AW = $clog2(NUM_LEVELS * LEVEL_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_RESP
  } state_t;

  state_t state;

  // Held from accept until the result is loaded.
  logic                prio_ok;
  logic [LW-1:0]       lvl;
  logic [STATUS_W-1:0] status;
  // Captured while the store read is in flight.
  logic                front_valid;
  logic [PRIO_W-1:0]   front_prio;
  logic [LCOUNT_W-1:0] level_count;
  logic [TOTAL_W-1:0]  total_count;

  logic                accept;
  logic                prio_ok_in;
  logic [LW-1:0]       lvl_in;
  logic [STATUS_W-1:0] status_in;
  logic                is_add;
  logic                is_remove;
  logic                load;

  lvl_cmd_t            cmd;
  lvl_stat_t           stat;
  logic [LW-1:0]       sel_lvl;
  logic [LW-1:0]       top_lvl;
  logic [PW-1:0]       top_slot;
  logic [PW-1:0]       sel_slot;
  logic [FW-1:0]       sel_fill;
  logic [TW-1:0]       total;

  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [TASK_BITS-1:0] wr_data;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic [TASK_BITS-1:0] rd_data;

  // Take a new item only when no earlier one is still in flight.
  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;

  // Decode the item: out-of-range priorities select level 0 and never add to it.
  assign prio_ok_in = (req.priority_req != '0) && (int'(req.priority_req) <= NUM_LEVELS);
  assign lvl_in     = prio_ok_in ? LW'(req.priority_req - 1'b1) : '0;
  assign is_add     = (req.kind == KIND_ADD);
  assign is_remove  = (req.kind == KIND_REMOVE);

  // Point the bookkeeping at the incoming level on accept, at the held one after.
  assign sel_lvl = (state == S_IDLE) ? lvl_in : lvl;

  assign cmd.add    = accept && is_add && prio_ok_in && !stat.sel_full;
  assign cmd.remove = accept && is_remove && stat.any;

  always_comb begin
    if (is_add && (!prio_ok_in || stat.sel_full)) begin
      status_in = STATUS_DROP;
    end else if (is_remove && !stat.any) begin
      status_in = STATUS_EMPTY;
    end else begin
      status_in = STATUS_OK;
    end
  end

  // Write the task at the level's tail in the same cycle the pointers advance.
  assign wr_en   = cmd.add;
  assign wr_addr = AW'(lvl_in) * AW'(LEVEL_DEPTH) + AW'(sel_slot);
  assign wr_data = TASK_BITS'(req.task_id);

  // Read the new front once the update has landed.
  assign rd_en   = (state == S_READ);
  assign rd_addr = AW'(top_lvl) * AW'(LEVEL_DEPTH) + AW'(top_slot);

  // Load the result when the output register is free or being drained.
  assign load = (state == S_RESP) && (!rsp_valid || rsp_ready);

  mlpq_levels #(
    .NUM_LEVELS  (NUM_LEVELS),
    .LEVEL_DEPTH (LEVEL_DEPTH)
  ) u_levels (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sel_lvl  (sel_lvl),
    .stat     (stat),
    .top_lvl  (top_lvl),
    .top_slot (top_slot),
    .sel_slot (sel_slot),
    .sel_fill (sel_fill),
    .total    (total)
  );

  mlpq_store #(
    .NUM_LEVELS  (NUM_LEVELS),
    .LEVEL_DEPTH (LEVEL_DEPTH),
    .TASK_BITS   (TASK_BITS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      // Present a freshly loaded result, or drop the one just taken.
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            prio_ok <= prio_ok_in;
            lvl     <= lvl_in;
            status  <= status_in;
            state   <= S_READ;
          end
        end
        S_READ: begin
          front_valid <= stat.any;
          front_prio  <= stat.any ? PRIO_W'(32'(top_lvl) + 32'd1) : '0;
          level_count <= prio_ok ? LCOUNT_W'(sel_fill) : '0;
          total_count <= TOTAL_W'(total);
          state       <= S_RESP;
        end
        S_RESP: begin
          if (load) begin
            rsp.front_valid    <= front_valid;
            rsp.front_task     <= front_valid ? TASK_W'(rd_data) : '0;
            rsp.front_priority <= front_prio;
            rsp.total_count    <= total_count;
            rsp.level_count    <= level_count;
            rsp.status         <= status;
            state              <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `MLPQ_ASSERT(a_accept_to_read, clk, rst, accept |=> (state == S_READ), "accept did not start read")
  `MLPQ_ASSERT(a_read_to_resp, clk, rst, (state == S_READ) |=> (state == S_RESP), "read not followed by result")
  `MLPQ_ASSERT(a_load_shows, clk, rst, load |=> rsp_valid, "loaded result not presented")
  `MLPQ_ASSERT(a_empty_front, clk, rst, (rsp_valid && !rsp.front_valid) |-> (rsp.front_task == '0 && rsp.front_priority == '0), "empty front not zero")

endmodule

`default_nettype wire

FILE: verif/multilevel_priority_queue_test.sv
// Self-checking testbench for the multilevel strict-priority task queue.
`timescale 1ns / 1ps

module multilevel_priority_queue_test;
  import mlpq_pkg::*;

  localparam int NUM_LEVELS  = NUM_LEVELS_DEF;
  localparam int LEVEL_DEPTH = LEVEL_DEPTH_DEF;
  localparam int TASK_BITS   = TASK_BITS_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;
  localparam int REQ_W       = $bits(mlpq_req_t);

  // Spare operation code; the block treats it as a query.
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  // Bits of a task identifier that the bank keeps.
  localparam logic [TASK_W-1:0] TASK_KEEP =
      (TASK_BITS >= TASK_W) ? '1 : TASK_W'((1 << TASK_BITS) - 1);

  logic      clk = 1'b0;
  logic      rst;
  logic      req_valid;
  logic      req_ready;
  mlpq_req_t req;
  logic      rsp_valid;
  logic      rsp_ready;
  mlpq_rsp_t rsp;

  // Shadow of the bank: one ring of task identifiers per level.
  logic [TASK_W-1:0] bank_ring [NUM_LEVELS][LEVEL_DEPTH];
  int unsigned       ring_head [NUM_LEVELS];
  int unsigned       ring_tail [NUM_LEVELS];
  int unsigned       ring_fill [NUM_LEVELS];

  // Bank views still owed by the block, oldest first.
  mlpq_rsp_t pending_bank_views [$];

  // Idle chance in percent for each side; zero means no idling.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  int cycle_count     = 0;
  int mismatches      = 0;
  int views_checked   = 0;
  int items_sent      = 0;
  int adds_seen       = 0;
  int adds_dropped    = 0;
  int removes_seen    = 0;
  int removes_empty   = 0;
  int queries_seen    = 0;
  int peak_occupancy  = 0;

  multilevel_priority_queue #(
    .NUM_LEVELS (NUM_LEVELS),
    .LEVEL_DEPTH(LEVEL_DEPTH),
    .TASK_BITS  (TASK_BITS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow bank
  // ---------------------------------------------------------------------------

  // Index of the highest non-empty level, or -1 when the bank is empty.
  function automatic int highest_busy_level();
    for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
      if (ring_fill[l] != 0) return l;
    end
    return -1;
  endfunction

  function automatic int bank_occupancy();
    int sum;
    sum = 0;
    for (int l = 0; l < NUM_LEVELS; l++) sum += ring_fill[l];
    return sum;
  endfunction

  // Apply one item to the shadow bank and return the view it should produce.
  function automatic mlpq_rsp_t bank_step(mlpq_req_t item);
    mlpq_rsp_t view;
    logic      prio_ok;
    int        lvl;
    int        top;
    int        total;
    view    = '0;
    prio_ok = (item.priority_req >= 1) && (item.priority_req <= NUM_LEVELS);
    lvl     = prio_ok ? int'(item.priority_req) - 1 : 0;
    view.status = STATUS_OK;
    case (item.kind)
      KIND_ADD: begin
        adds_seen++;
        // Drop on a full level or on a level number outside the bank.
        if (!prio_ok || ring_fill[lvl] >= LEVEL_DEPTH) begin
          view.status = STATUS_DROP;
          adds_dropped++;
        end else begin
          bank_ring[lvl][ring_tail[lvl]] = item.task_id & TASK_KEEP;
          ring_tail[lvl] = (ring_tail[lvl] + 1) % LEVEL_DEPTH;
          ring_fill[lvl]++;
        end
      end
      KIND_REMOVE: begin
        removes_seen++;
        top = highest_busy_level();
        if (top < 0) begin
          view.status = STATUS_EMPTY;
          removes_empty++;
        end else begin
          ring_head[top] = (ring_head[top] + 1) % LEVEL_DEPTH;
          ring_fill[top]--;
        end
      end
      default: queries_seen++;
    endcase
    top = highest_busy_level();
    if (top >= 0) begin
      view.front_valid    = 1'b1;
      view.front_task     = bank_ring[top][ring_head[top]];
      view.front_priority = PRIO_W'(top + 1);
    end
    total = bank_occupancy();
    if (total > peak_occupancy) peak_occupancy = total;
    view.total_count = TOTAL_W'(total);
    view.level_count = prio_ok ? LCOUNT_W'(ring_fill[lvl]) : '0;
    return view;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and checking
  // ---------------------------------------------------------------------------

  // Lower ready for a random burst whenever a draw falls below the receive idle chance.
  initial begin : rsp_ready_driver
    int stall_left;
    stall_left = 0;
    rsp_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        rsp_ready <= 1'b0;
      end else if (recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct) begin
        stall_left = $urandom_range(5);
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  task automatic note_field(input string field, input int unsigned want,
                            input int unsigned got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("Mismatch on view %0d, %s: expected 0x%0h, got 0x%0h",
                 views_checked, field, want, got);
    end
  endtask

  // Compare each taken view against the oldest one owed.
  always @(posedge clk) begin : view_checker
    mlpq_rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_bank_views.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("Unexpected view with nothing owed: 0x%0h", rsp);
      end else begin
        want = pending_bank_views.pop_front();
        note_field("front_valid", want.front_valid, rsp.front_valid);
        note_field("front_task", want.front_task, rsp.front_task);
        note_field("front_priority", want.front_priority, rsp.front_priority);
        note_field("total_count", want.total_count, rsp.total_count);
        note_field("level_count", want.level_count, rsp.level_count);
        note_field("status", want.status, rsp.status);
      end
      views_checked++;
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Drive one item at the falling edge, hold it until taken, then predict.
  // Valid stays high on return; an idle gap before the next send or a wait for views lowers it.
  task automatic send_item(input mlpq_req_t item);
    int gap;
    gap = 0;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
      gap = $urandom_range(1, 6);
    repeat (gap) begin
      @(negedge clk);
      req_valid <= 1'b0;
      req       <= REQ_W'($urandom);
    end
    @(negedge clk);
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    pending_bank_views.push_back(bank_step(item));
    items_sent++;
  endtask

  task automatic send_fields(input logic [KIND_W-1:0] kind,
                             input logic [TASK_W-1:0] task_id,
                             input logic [PRIO_W-1:0] prio);
    mlpq_req_t item;
    item.kind         = kind;
    item.task_id      = task_id;
    item.priority_req = prio;
    send_item(item);
  endtask

  // Drop valid and hold the sender until every owed view has come back.
  task automatic wait_for_all_views();
    @(negedge clk);
    req_valid <= 1'b0;
    while (pending_bank_views.size() != 0) @(posedge clk);
  endtask

  // Random item with the given add and remove chances; the rest are queries.
  function automatic mlpq_req_t random_item(input int add_pct, input int remove_pct);
    mlpq_req_t item;
    int        pick;
    int        off;
    pick = $urandom_range(99);
    if (pick < add_pct)
      item.kind = KIND_ADD;
    else if (pick < add_pct + remove_pct)
      item.kind = KIND_REMOVE;
    else
      item.kind = ($urandom_range(3) == 0) ? KIND_SPARE : KIND_QUERY;
    case ($urandom_range(15))
      0:       item.task_id = '0;
      1:       item.task_id = '1;
      default: item.task_id = TASK_W'($urandom_range(16'hFFFF));
    endcase
    // Mostly levels inside the bank, now and then zero or a level above the top.
    if ($urandom_range(15) == 0) begin
      off = $urandom_range(2 ** PRIO_W - 1 - NUM_LEVELS);
      item.priority_req = (off == 0) ? '0 : PRIO_W'(NUM_LEVELS + off);
    end else begin
      item.priority_req = PRIO_W'($urandom_range(NUM_LEVELS, 1));
    end
    return item;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, every operation and each corner on a small bank.
  task automatic test_directed_corners();
    send_fields(KIND_QUERY, '0, PRIO_W'(1));              // query an empty bank
    send_fields(KIND_REMOVE, '0, PRIO_W'(1));             // remove from empty bank
    send_fields(KIND_ADD, '0, PRIO_W'(1));                // lowest id, lowest level
    send_fields(KIND_ADD, '1, PRIO_W'(NUM_LEVELS));       // highest id, top level
    send_fields(KIND_ADD, 16'h1234, '0);                  // level zero drops
    send_fields(KIND_ADD, 16'h4321, PRIO_W'(NUM_LEVELS + 1));
    send_fields(KIND_ADD, 16'hBEEF, '1);                  // largest level number
    send_fields(KIND_QUERY, '0, '0);                      // count of level zero
    send_fields(KIND_SPARE, 16'hA5A5, '1);                // spare code, bad level
    send_fields(KIND_SPARE, 16'hA5A5, PRIO_W'(NUM_LEVELS)); // spare code adds nothing
    send_fields(KIND_ADD, 16'h5A5A, PRIO_W'(4));
    send_fields(KIND_REMOVE, '1, PRIO_W'(NUM_LEVELS + 4)); // remove, bad level count
    send_fields(KIND_REMOVE, '0, PRIO_W'(1));
    send_fields(KIND_REMOVE, '0, PRIO_W'(4));
    send_fields(KIND_REMOVE, '0, '1);                     // empty again
  endtask

  // Fill one level to the brim, overflow it, then drain the whole bank.
  task automatic test_level_overflow();
    int lvl;
    lvl = $urandom_range(NUM_LEVELS, 1);
    repeat (LEVEL_DEPTH + 1)
      send_fields(KIND_ADD, TASK_W'($urandom_range(16'hFFFF)), PRIO_W'(lvl));
    send_fields(KIND_ADD, TASK_W'($urandom_range(16'hFFFF)), PRIO_W'(NUM_LEVELS + 1 - lvl));
    while (bank_occupancy() != 0)
      send_fields(KIND_REMOVE, TASK_W'($urandom), PRIO_W'(lvl));
    send_fields(KIND_REMOVE, TASK_W'($urandom), PRIO_W'(lvl));
  endtask

  // Segments that push the bank toward full, toward empty, or hold it level,
  // with idling switched on and off between segments.
  task automatic test_random_traffic(input int segments, input int seg_len);
    int add_pct;
    int remove_pct;
    for (int s = 0; s < segments; s++) begin
      case (s % 3)
        0:       begin add_pct = 65; remove_pct = 20; end
        1:       begin add_pct = 20; remove_pct = 65; end
        default: begin add_pct = 40; remove_pct = 40; end
      endcase
      send_idle_pct = (s % 4 == 3) ? 0 : 10 * $urandom_range(4);
      recv_idle_pct = (s % 4 == 3) ? 0 : 10 * $urandom_range(4);
      repeat (seg_len) send_item(random_item(add_pct, remove_pct));
    end
  endtask

  // Hold the sender until the block has returned every view, twice over.
  task automatic test_sender_hold();
    send_idle_pct = 20;
    recv_idle_pct = 30;
    repeat (2) begin
      repeat (40) send_item(random_item(50, 30));
      wait_for_all_views();
    end
  endtask

  // Full-rate stretch with no idling on either side.
  task automatic test_back_to_back(input int count);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int n = 0; n < count; n++)
      send_item((n < count / 2) ? random_item(70, 20) : random_item(20, 70));
  endtask

  // ---------------------------------------------------------------------------
  // Run
  // ---------------------------------------------------------------------------

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d views owed",
             cycle_count, pending_bank_views.size());
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : main_sequence
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    for (int l = 0; l < NUM_LEVELS; l++) begin
      ring_head[l] = 0;
      ring_tail[l] = 0;
      ring_fill[l] = 0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_corners();
    test_level_overflow();
    test_random_traffic(12, 120);
    test_sender_hold();
    test_back_to_back(220);

    // Let the last views drain, then wait for any strays.
    wait_for_all_views();
    repeat (8) @(posedge clk);

    if (pending_bank_views.size() != 0) begin
      mismatches += pending_bank_views.size();
      $display("%0d views never arrived", pending_bank_views.size());
    end
    $display("Sent %0d items: %0d adds (%0d dropped), %0d removes (%0d on an empty bank),",
             items_sent, adds_seen, adds_dropped, removes_seen, removes_empty);
    $display("%0d queries; peak occupancy %0d of %0d; %0d views checked, %0d mismatches.",
             queries_seen, peak_occupancy, NUM_LEVELS * LEVEL_DEPTH, views_checked,
             mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
